[src/dlr_pkg.sv]
// Shared types and constants for the delayed linear ramp block.
// No dependencies; compiled first.
package dlr_pkg;

  localparam int unsigned LevelWidthDef = 24;
  localparam int unsigned TimeWidthDef  = 32;
  localparam int unsigned TickWidth     = 20;
  localparam int unsigned DelayWidth    = 32;
  localparam int unsigned CfgIdxWidth   = 2;
  localparam int unsigned CfgDataWidth  = 32;
  localparam int unsigned StatusWidth   = 2;

  typedef enum logic [1:0] {
    PH_PENDING  = 2'd0,
    PH_ACTIVE   = 2'd1,
    PH_FINISHED = 2'd2
  } phase_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_START_DELAY  = 2'd0,
    REG_RAMP_LENGTH  = 2'd1,
    REG_TARGET_LEVEL = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCUM,
    S_EVAL,
    S_CHECK,
    S_DIV,
    S_LEVEL,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_SHIFT,
    DV_ADD
  } div_state_e;

endpackage

[src/dlr_ifs.sv]
// Handshake interfaces: tick requests in, results out, register writes.
// Depends on dlr_pkg.
interface dlr_tick_if
  import dlr_pkg::*;
#(
  parameter int unsigned LEVEL_WIDTH = LevelWidthDef
) ();
  logic                   valid;
  logic                   ready;
  logic [TickWidth-1:0]   tick_time;
  logic [LEVEL_WIDTH-1:0] current_level;
  logic                   source_valid;
  logic                   rearm;

  modport source (output valid, tick_time, current_level, source_valid, rearm, input ready);
  modport sink   (input valid, tick_time, current_level, source_valid, rearm, output ready);
endinterface

interface dlr_result_if
  import dlr_pkg::*;
#(
  parameter int unsigned LEVEL_WIDTH = LevelWidthDef
) ();
  logic                   valid;
  logic                   ready;
  logic                   write_enable;
  logic [LEVEL_WIDTH-1:0] level_out;
  logic [StatusWidth-1:0] ramp_status;

  modport source (output valid, write_enable, level_out, ramp_status, input ready);
  modport sink   (input valid, write_enable, level_out, ramp_status, output ready);
endinterface

interface dlr_cfg_if
  import dlr_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CfgIdxWidth-1:0]  index;
  logic [CfgDataWidth-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/delayed_linear_ramp.sv]
// Delayed linear ramp generator, top level.
// Depends on dlr_pkg, dlr_ifs and dlr_scale_div.
//
// Channel   | Dir | Handshake     | Payload
// ----------+-----+---------------+------------------------------------------
// tick_i    | in  | valid/ready   | tick_time, current_level, source_valid, rearm
// cfg_i     | in  | valid/ready   | index, data (register write, always ready)
// result_o  | out | valid/ready   | write_enable, level_out, ramp_status
//
// An interpolating tick request steps through ACCUM, EVAL, CHECK, the serial
// divide (two steps per quotient bit) and LEVEL to OUT; ticks that only wait,
// finish or jump to the target leave out the divide. tick_i is ready only in idle.
// A finished result sits in the output register; the next tick is accepted
// while it waits, and the sequencer holds its own result until that is taken.
// Reset clears the configuration registers, state, phase, elapsed time, start level and output valid.
module delayed_linear_ramp
  import dlr_pkg::*;
#(
  parameter int unsigned LEVEL_WIDTH = LevelWidthDef,
  parameter int unsigned TIME_WIDTH  = TimeWidthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dlr_tick_if.sink     tick_i,
  dlr_cfg_if.sink      cfg_i,
  dlr_result_if.source result_o
);

  localparam int unsigned SumW = ((TIME_WIDTH > TickWidth) ? TIME_WIDTH : TickWidth) + 1;
  localparam int unsigned CmpW = (TIME_WIDTH > DelayWidth) ? TIME_WIDTH : DelayWidth;

  // configuration
  logic [DelayWidth-1:0]  delay_q, len_q;
  logic [LEVEL_WIDTH-1:0] target_q;

  // ramp state
  state_e                 state_q, state_d;
  phase_e                 phase_q, phase_d;
  logic [TIME_WIDTH-1:0]  elapsed_q, elapsed_d;
  logic [LEVEL_WIDTH-1:0] start_q, start_d;

  // latched tick request
  logic [TickWidth-1:0]   dt_q;
  logic [LEVEL_WIDTH-1:0] cur_q;
  logic                   src_ok_q, rearm_q;

  // working values
  logic [CmpW-1:0]        prog_q, prog_d;
  logic                   neg_q, neg_d;
  logic [LEVEL_WIDTH:0]   mag_q, mag_d;
  logic                   wr_q, wr_d;
  logic [LEVEL_WIDTH-1:0] lvl_q, lvl_d;

  // output register
  logic                   ovalid_q, ovalid_d;
  logic                   owe_q;
  logic [LEVEL_WIDTH-1:0] olvl_q;
  phase_e                 ost_q;

  logic                   tick_acc, load_out, div_start, div_done;
  logic [LEVEL_WIDTH:0]   quot;

  // ---- intermediate arithmetic
  logic [TIME_WIDTH-1:0]  el_base;
  phase_e                 ph_base;
  logic [SumW-1:0]        el_sum;
  logic [CmpW-1:0]        el_ext, delay_ext, len_ext;
  logic                   past_delay, go_active, jump;
  logic [LEVEL_WIDTH:0]   diff, st_ext, lvl_sum;

  assign tick_acc = tick_i.valid && tick_i.ready;
  assign load_out = (state_q == S_OUT) && (!ovalid_q || result_o.ready);

  always_comb begin
    el_base    = rearm_q ? '0 : elapsed_q;
    ph_base    = rearm_q ? PH_PENDING : phase_q;
    el_sum     = SumW'(el_base) + SumW'(dt_q);
    el_ext     = CmpW'(elapsed_q);
    delay_ext  = CmpW'(delay_q);
    len_ext    = CmpW'(len_q);
    past_delay = el_ext > delay_ext;
    go_active  = (phase_q == PH_ACTIVE) || ((phase_q == PH_PENDING) && past_delay);
    jump       = (len_q == '0) || (prog_q > len_ext);
    st_ext     = {start_q[LEVEL_WIDTH-1], start_q};
    diff       = {target_q[LEVEL_WIDTH-1], target_q} - st_ext;
    lvl_sum    = neg_q ? (st_ext - quot) : (st_ext + quot);
  end

  // ---- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (tick_acc) state_d = S_ACCUM;
      S_ACCUM: state_d = src_ok_q ? S_EVAL : S_OUT;
      S_EVAL:  state_d = go_active ? S_CHECK : S_OUT;
      S_CHECK: state_d = jump ? S_OUT : S_DIV;
      S_DIV:   if (div_done) state_d = S_LEVEL;
      S_LEVEL: state_d = S_OUT;
      S_OUT:   if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // ---- datapath updates
  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    start_d   = start_q;
    prog_d    = prog_q;
    neg_d     = neg_q;
    mag_d     = mag_q;
    wr_d      = wr_q;
    lvl_d     = lvl_q;
    div_start = 1'b0;
    unique case (state_q)
      S_ACCUM: begin
        wr_d  = 1'b0;
        lvl_d = '0;
        if (!src_ok_q) begin
          // dead source: finish, elapsed not advanced
          elapsed_d = el_base;
          phase_d   = PH_FINISHED;
        end else begin
          // elapsed time saturates at all ones
          elapsed_d = (|el_sum[SumW-1:TIME_WIDTH]) ? '1 : el_sum[TIME_WIDTH-1:0];
          phase_d   = ph_base;
        end
      end
      S_EVAL: begin
        prog_d = past_delay ? (el_ext - delay_ext) : '0;
        if ((phase_q == PH_PENDING) && past_delay) begin
          start_d = cur_q;
          phase_d = PH_ACTIVE;
        end
      end
      S_CHECK: begin
        wr_d = 1'b1;
        if (jump) begin
          lvl_d   = target_q;
          phase_d = PH_FINISHED;
        end else begin
          neg_d     = diff[LEVEL_WIDTH];
          mag_d     = diff[LEVEL_WIDTH] ? (~diff + 1'b1) : diff;
          div_start = 1'b1;
        end
      end
      S_LEVEL: lvl_d = lvl_sum[LEVEL_WIDTH-1:0];
      default: ;
    endcase
  end

  // mag is registered in the CHECK cycle, divider latches it in the next cycle
  logic div_go_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_go_q <= 1'b0;
    end else begin
      div_go_q <= div_start;
    end
  end

  dlr_scale_div #(
    .LEVEL_WIDTH(LEVEL_WIDTH)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_go_q),
    .mag_i  (mag_q),
    .prog_i (prog_q[DelayWidth-1:0]),
    .len_i  (len_q),
    .done_o (div_done),
    .quot_o (quot)
  );

  // ---- output register
  always_comb begin
    ovalid_d = ovalid_q;
    if (load_out) begin
      ovalid_d = 1'b1;
    end else if (result_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  // ---- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_PENDING;
      elapsed_q <= '0;
      start_q   <= '0;
      ovalid_q  <= 1'b0;
      delay_q   <= '0;
      len_q     <= '0;
      target_q  <= '0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      start_q   <= start_d;
      ovalid_q  <= ovalid_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          REG_START_DELAY:  delay_q  <= cfg_i.data[DelayWidth-1:0];
          REG_RAMP_LENGTH:  len_q    <= cfg_i.data[DelayWidth-1:0];
          REG_TARGET_LEVEL: target_q <= cfg_i.data[LEVEL_WIDTH-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      dt_q     <= tick_i.tick_time;
      cur_q    <= tick_i.current_level;
      src_ok_q <= tick_i.source_valid;
      rearm_q  <= tick_i.rearm;
    end
    prog_q <= prog_d;
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    wr_q   <= wr_d;
    lvl_q  <= lvl_d;
    if (load_out) begin
      owe_q  <= wr_q;
      olvl_q <= lvl_q;
      ost_q  <= phase_q;
    end
  end

  assign tick_i.ready          = (state_q == S_IDLE);
  assign cfg_i.ready           = 1'b1;
  assign result_o.valid        = ovalid_q;
  assign result_o.write_enable = owe_q;
  assign result_o.level_out    = olvl_q;
  assign result_o.ramp_status  = ost_q;

endmodule

[src/dlr_scale_div.sv]
// Serial scaled divider: q = floor(mag * prog / len), prog <= len, len > 0.
// One shared subtractor, a shift step and an add step per quotient bit. Depends on dlr_pkg.
module dlr_scale_div
  import dlr_pkg::*;
#(
  parameter int unsigned LEVEL_WIDTH = LevelWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [LEVEL_WIDTH:0] mag_i,
  input  logic [DelayWidth-1:0] prog_i,
  input  logic [DelayWidth-1:0] len_i,
  output logic                 done_o,
  output logic [LEVEL_WIDTH:0] quot_o
);

  localparam int unsigned CntW = $clog2(LEVEL_WIDTH + 1);

  div_state_e              st_q, st_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    done_q, done_d;
  logic [LEVEL_WIDTH:0]    mag_q, mag_d;
  logic [LEVEL_WIDTH:0]    quot_q, quot_d;
  logic [DelayWidth-1:0]   rem_q, rem_d;
  logic [DelayWidth-1:0]   prog_q, prog_d;
  logic [DelayWidth-1:0]   len_q, len_d;
  logic [DelayWidth-1:0]   gap_q, gap_d;   // len - prog

  // shared subtractor
  logic [DelayWidth:0]     op_a, op_b;
  logic [DelayWidth+1:0]   sub;
  logic                    borrow;

  always_comb begin
    if (st_q == DV_SHIFT) begin
      op_a = {rem_q, 1'b0};
      op_b = {1'b0, len_q};
    end else begin
      op_a = {1'b0, rem_q};
      op_b = {1'b0, gap_q};
    end
    sub    = {1'b0, op_a} - {1'b0, op_b};
    borrow = sub[DelayWidth+1];
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      DV_IDLE:  if (start_i) st_d = DV_SHIFT;
      DV_SHIFT: st_d = DV_ADD;
      DV_ADD:   st_d = (cnt_q == '0) ? DV_IDLE : DV_SHIFT;
      default:  st_d = DV_IDLE;
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    mag_d  = mag_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    prog_d = prog_q;
    len_d  = len_q;
    gap_d  = gap_q;
    unique case (st_q)
      DV_IDLE: begin
        if (start_i) begin
          mag_d  = mag_i;
          prog_d = prog_i;
          len_d  = len_i;
          gap_d  = len_i - prog_i;
          rem_d  = '0;
          quot_d = '0;
          cnt_d  = CntW'(LEVEL_WIDTH);
        end
      end
      DV_SHIFT: begin
        // double the remainder, take out len once
        quot_d = {quot_q[LEVEL_WIDTH-1:0], ~borrow};
        rem_d  = borrow ? op_a[DelayWidth-1:0] : sub[DelayWidth-1:0];
      end
      DV_ADD: begin
        // add prog for a set multiplicand bit; r + p >= len iff r >= len - p
        if (mag_q[LEVEL_WIDTH]) begin
          if (borrow) begin
            rem_d = rem_q + prog_q;
          end else begin
            rem_d  = sub[DelayWidth-1:0];
            quot_d = quot_q + 1'b1;
          end
        end
        mag_d = {mag_q[LEVEL_WIDTH-1:0], 1'b0};
        if (cnt_q == '0) begin
          done_d = 1'b1;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= DV_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    mag_q  <= mag_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    prog_q <= prog_d;
    len_q  <= len_d;
    gap_q  <= gap_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[src/dlr_checker.sv]
// Port-level checks for delayed_linear_ramp, attached by bind.
// Depends on dlr_pkg.
module dlr_checker
  import dlr_pkg::*;
#(
  parameter int unsigned LEVEL_WIDTH = LevelWidthDef
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   tick_valid,
  input logic                   tick_ready,
  input logic                   res_valid,
  input logic                   res_ready,
  input logic                   res_we,
  input logic [LEVEL_WIDTH-1:0] res_level,
  input logic [StatusWidth-1:0] res_status
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_level) && $stable(res_we)
      && $stable(res_status))
    else $error("result changed while stalled");

  // one tick at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_valid && tick_ready |=> !tick_ready)
    else $error("tick accepted back to back");

  // no write means a zero level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_we |-> res_level == '0)
    else $error("level without write");

  // a write never leaves the ramp pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_we |-> res_status != PH_PENDING)
    else $error("write while pending");

endmodule

bind delayed_linear_ramp dlr_checker #(
  .LEVEL_WIDTH(LEVEL_WIDTH)
) u_dlr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .tick_valid(tick_i.valid),
  .tick_ready(tick_i.ready),
  .res_valid (result_o.valid),
  .res_ready (result_o.ready),
  .res_we    (result_o.write_enable),
  .res_level (result_o.level_out),
  .res_status(result_o.ramp_status)
);

[test/tb_delayed_linear_ramp.sv]
// Self-checking testbench for delayed_linear_ramp: directed table, long-tick sweep and
// random ramps, with results checked against an in-bench ramp predictor.
// Depends on dlr_pkg, dlr_ifs and the delayed_linear_ramp RTL.
module tb_delayed_linear_ramp;
  import dlr_pkg::*;

  localparam int unsigned LW         = LevelWidthDef;
  // Longest correct stretch with no handshake is the forced result hold-off
  // plus one interpolating tick and a sender gap; the limit leaves a wide margin.
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldOff    = 300;
  localparam int unsigned RandTicks  = 1400;
  localparam int unsigned CalmFrom   = 1250;
  localparam int unsigned LongTicks  = 24;     // max-length ticks while held pending

  typedef struct packed {
    logic [TickWidth-1:0] dt;
    logic [LW-1:0]        cur;
    logic                 sv;
    logic                 rearm;
  } tick_t;

  typedef struct packed {
    logic                   we;
    logic [LW-1:0]          lvl;
    logic [StatusWidth-1:0] status;
  } ramp_res_t;

  // One row of the directed plan: a register write or a tick request,
  // the latter optionally with its result typed in.
  typedef struct {
    bit          cfg_row;
    cfg_reg_e    reg_sel;
    logic [31:0] wdata;
    tick_t       tk;
    bit          typed;
    ramp_res_t   want;
  } row_t;

  logic clk_i;
  logic rst_ni;

  dlr_tick_if   #(.LEVEL_WIDTH(LW)) tick_bus ();
  dlr_cfg_if                        cfg_bus ();
  dlr_result_if #(.LEVEL_WIDTH(LW)) res_bus ();

  delayed_linear_ramp dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick_bus),
    .cfg_i   (cfg_bus),
    .result_o(res_bus)
  );

  // Predictor copy of registers and ramp state.
  logic [31:0]   p_delay;
  logic [31:0]   p_len;
  logic [LW-1:0] p_target;
  phase_e        p_phase;
  logic [31:0]   p_elapsed;
  logic [LW-1:0] p_start;

  ramp_res_t ramp_out_q[$];     // results owed by the block, oldest first
  ramp_res_t got_r;
  ramp_res_t want_r;
  row_t      plan[$];

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned quiet_cycles;
  bit          src_idle;        // sender may insert gaps
  bit          snk_idle;        // receiver may stall
  bit          calm;            // tail of the run: no idling at all

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 100)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Next ramp state and the result for one tick. Rearm is applied first; an
  // invalid source finishes without advancing time; elapsed time saturates.
  function automatic ramp_res_t ramp_next(input tick_t t);
    logic [32:0]        sum;
    logic [31:0]        prog;
    logic signed [LW:0] diff;
    logic [LW:0]        mag;
    logic [63:0]        q;
    logic [LW:0]        lvl;
    ramp_res_t          r;
    r = '0;
    if (t.rearm) begin
      p_elapsed = '0;
      p_phase   = PH_PENDING;
    end
    if (!t.sv) begin
      p_phase = PH_FINISHED;
    end else begin
      sum       = {1'b0, p_elapsed} + 33'(t.dt);
      p_elapsed = sum[32] ? '1 : sum[31:0];
      if (p_phase == PH_PENDING && p_elapsed > p_delay) begin
        p_start = t.cur;
        p_phase = PH_ACTIVE;
      end
      if (p_phase == PH_ACTIVE) begin
        // delay raised past elapsed time while active: hold at start level
        prog = (p_elapsed > p_delay) ? p_elapsed - p_delay : '0;
        r.we = 1'b1;
        if (p_len == '0 || prog > p_len) begin
          r.lvl   = p_target;
          p_phase = PH_FINISHED;
        end else begin
          diff  = {p_target[LW-1], p_target} - {p_start[LW-1], p_start};
          mag   = diff[LW] ? -diff : diff;
          // magnitude scaled, so the quotient truncates toward zero
          q     = (64'(mag) * 64'(prog)) / 64'(p_len);
          lvl   = diff[LW] ? {p_start[LW-1], p_start} - (LW+1)'(q)
                           : {p_start[LW-1], p_start} + (LW+1)'(q);
          r.lvl = lvl[LW-1:0];
        end
      end
    end
    r.status = p_phase;
    return r;
  endfunction

  function automatic row_t tick_row(input logic [TickWidth-1:0] dt, input logic [LW-1:0] cur,
                                    input bit sv, input bit rearm);
    row_t row;
    row          = '{reg_sel: REG_START_DELAY, default: '0};
    row.tk.dt    = dt;
    row.tk.cur   = cur;
    row.tk.sv    = sv;
    row.tk.rearm = rearm;
    return row;
  endfunction

  function automatic row_t known_row(input logic [TickWidth-1:0] dt, input logic [LW-1:0] cur,
                                     input bit sv, input bit rearm, input bit we,
                                     input logic [LW-1:0] lvl, input phase_e st);
    row_t row;
    row             = tick_row(dt, cur, sv, rearm);
    row.typed       = 1'b1;
    row.want.we     = we;
    row.want.lvl    = lvl;
    row.want.status = st;
    return row;
  endfunction

  function automatic row_t reg_row(input cfg_reg_e sel, input logic [31:0] data);
    row_t row;
    row         = '{reg_sel: REG_START_DELAY, default: '0};
    row.cfg_row = 1'b1;
    row.reg_sel = sel;
    row.wdata   = data;
    return row;
  endfunction

  // Offer one tick request, optionally after a gap, and log its result once
  // the block takes it. Leaves valid high; the next call or a drain decides.
  task automatic send_tick(input tick_t t, input bit typed, input ramp_res_t known);
    int unsigned gap;
    ramp_res_t   r;
    gap = 0;
    cfg_bus.valid <= 1'b0;
    if (src_idle && !calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
    if (gap != 0) begin
      tick_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick_bus.valid         <= 1'b1;
    tick_bus.tick_time     <= t.dt;
    tick_bus.current_level <= t.cur;
    tick_bus.source_valid  <= t.sv;
    tick_bus.rearm         <= t.rearm;
    do @(posedge clk_i); while (!tick_bus.ready);
    r = ramp_next(t);
    ramp_out_q.push_back(typed ? known : r);
  endtask

  // Register write; valid stays high so back-to-back writes need no gap.
  task automatic cfg_write(input cfg_reg_e sel, input logic [31:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= sel;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (sel)
      REG_START_DELAY:  p_delay  = data;
      REG_RAMP_LENGTH:  p_len    = data;
      REG_TARGET_LEVEL: p_target = data[LW-1:0];
      default: ;
    endcase
  endtask

  // Stop offering, let every owed result come back, then a short settle.
  task automatic drain_idle();
    tick_bus.valid <= 1'b0;
    cfg_bus.valid  <= 1'b0;
    while (ramp_out_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Receiver: random stall bursts, plus one long hold-off once traffic is
  // flowing so the output register and sequencer fill and tick_i backs up.
  initial begin
    bit          held;
    int unsigned n;
    held = 1'b0;
    forever begin
      if (!held && results_seen >= 200) begin
        held = 1'b1;
        res_bus.ready <= 1'b0;
        n = HoldOff;
      end else if (snk_idle && !calm && $urandom_range(0, 4) == 0) begin
        res_bus.ready <= 1'b0;
        n = $urandom_range(1, 12);
      end else begin
        res_bus.ready <= 1'b1;
        n = 1;
      end
      repeat (n) @(posedge clk_i);
    end
  end

  // Result checker and handshake activity counter.
  always @(posedge clk_i) begin
    if ((tick_bus.valid && tick_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
        (res_bus.valid && res_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      results_seen++;
      got_r.we     = res_bus.write_enable;
      got_r.lvl    = res_bus.level_out;
      got_r.status = res_bus.ramp_status;
      if (ramp_out_q.size() == 0) begin
        report_mismatch("result with none owed", 32'(got_r), 32'h0);
      end else begin
        want_r = ramp_out_q.pop_front();
        if (got_r.we !== want_r.we)
          report_mismatch("write_enable", 32'(got_r.we), 32'(want_r.we));
        if (got_r.lvl !== want_r.lvl)
          report_mismatch("level_out", 32'(got_r.lvl), 32'(want_r.lvl));
        if (got_r.status !== want_r.status)
          report_mismatch("ramp_status", 32'(got_r.status), 32'(want_r.status));
      end
    end
  end

  // Watchdog: too long without any request moving on any channel.
  initial begin
    wait (rst_ni === 1'b1);
    while (quiet_cycles < StallLimit) @(posedge clk_i);
    $display("tb_delayed_linear_ramp failed");
    $finish;
  end

  initial begin
    tick_t       t;
    int unsigned delay_v;
    int unsigned len_v;
    int unsigned n;
    int unsigned base;
    int unsigned rand_sent;
    logic [33:0] span;

    rst_ni                 = 1'b0;
    tick_bus.valid         = 1'b0;
    tick_bus.tick_time     = '0;
    tick_bus.current_level = '0;
    tick_bus.source_valid  = 1'b0;
    tick_bus.rearm         = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = REG_START_DELAY;
    cfg_bus.data           = '0;
    mismatches             = 0;
    results_seen           = 0;
    quiet_cycles           = 0;
    src_idle               = 1'b1;
    snk_idle               = 1'b1;
    calm                   = 1'b0;
    rand_sent              = 0;
    // predictor mirrors the reset state: registers zero, pending, no time
    p_delay   = '0;
    p_len     = '0;
    p_target  = '0;
    p_phase   = PH_PENDING;
    p_elapsed = '0;
    p_start   = '0;

    // Directed plan. Typed results are the ones obvious from the rules.
    // Reset registers: zero delay and zero length, so the first tick with
    // time on it starts and jumps straight to a zero target.
    plan.push_back(known_row(20'd0, 24'h000005, 1, 0, 0, '0, PH_PENDING));
    plan.push_back(known_row(20'd1, 24'h123456, 1, 0, 1, '0, PH_FINISHED));
    // finished holds without writes; invalid source keeps it finished
    plan.push_back(known_row(20'hFFFFF, 24'hFFFFFF, 1, 0, 0, '0, PH_FINISHED));
    plan.push_back(known_row(20'd0, 24'h000000, 0, 0, 0, '0, PH_FINISHED));
    // full-scale ramp from the most negative start up to the positive max
    plan.push_back(reg_row(REG_START_DELAY, 32'd100));
    plan.push_back(reg_row(REG_RAMP_LENGTH, 32'd1000));
    plan.push_back(reg_row(REG_TARGET_LEVEL, 32'h007FFFFF));
    plan.push_back(known_row(20'd50, 24'h800000, 1, 1, 0, '0, PH_PENDING));
    plan.push_back(tick_row(20'd60, 24'h800000, 1, 0));
    plan.push_back(tick_row(20'd500, 24'h2AAAAA, 1, 0));
    // progress equal to length lands exactly on target, still active
    plan.push_back(known_row(20'd490, 24'h555555, 1, 0, 1, 24'h7FFFFF, PH_ACTIVE));
    plan.push_back(known_row(20'd1, 24'h000000, 1, 0, 1, 24'h7FFFFF, PH_FINISHED));
    // upper data bits beyond the level width are dropped; max length
    plan.push_back(reg_row(REG_TARGET_LEVEL, 32'hA5800001));
    plan.push_back(reg_row(REG_START_DELAY, 32'd0));
    plan.push_back(reg_row(REG_RAMP_LENGTH, 32'hFFFFFFFF));
    plan.push_back(tick_row(20'hFFFFF, 24'h7FFFFF, 1, 1));
    plan.push_back(tick_row(20'd0, 24'h000000, 1, 0));
    // source lost mid-ramp, then rearm together with an invalid source
    plan.push_back(known_row(20'd0, 24'h000000, 0, 0, 0, '0, PH_FINISHED));
    plan.push_back(known_row(20'd0, 24'h000000, 0, 1, 0, '0, PH_FINISHED));
    // delay raised above elapsed time while active: output parks at start
    plan.push_back(reg_row(REG_START_DELAY, 32'd100));
    plan.push_back(reg_row(REG_RAMP_LENGTH, 32'd1000));
    plan.push_back(reg_row(REG_TARGET_LEVEL, 32'd0));
    plan.push_back(tick_row(20'd200, 24'h001000, 1, 1));
    plan.push_back(reg_row(REG_START_DELAY, 32'hFFFFFFFF));
    plan.push_back(known_row(20'd0, 24'h000000, 1, 0, 1, 24'h001000, PH_ACTIVE));
    plan.push_back(known_row(20'd5, 24'hABCDEF, 1, 0, 1, 24'h001000, PH_ACTIVE));
    // zero length while active, then a fresh start into a zero length
    plan.push_back(reg_row(REG_START_DELAY, 32'd300));
    plan.push_back(reg_row(REG_RAMP_LENGTH, 32'd0));
    plan.push_back(known_row(20'd0, 24'h000000, 1, 0, 1, '0, PH_FINISHED));
    plan.push_back(known_row(20'd301, 24'h7FFFFF, 1, 1, 1, '0, PH_FINISHED));
    // short downward ramp: quotient truncation toward zero on small steps
    plan.push_back(reg_row(REG_START_DELAY, 32'd0));
    plan.push_back(reg_row(REG_RAMP_LENGTH, 32'd3));
    plan.push_back(reg_row(REG_TARGET_LEVEL, 32'h00FFFFFF));
    plan.push_back(tick_row(20'd1, 24'h000001, 1, 1));
    plan.push_back(tick_row(20'd1, 24'h000000, 1, 0));
    plan.push_back(tick_row(20'd1, 24'h000000, 1, 0));
    plan.push_back(known_row(20'd1, 24'h000000, 1, 0, 1, 24'hFFFFFF, PH_FINISHED));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].cfg_row) begin
        if (i == 0 || !plan[i-1].cfg_row) drain_idle();
        cfg_write(plan[i].reg_sel, plan[i].wdata);
      end else begin
        send_tick(plan[i].tk, plan[i].typed, plan[i].want);
      end
    end

    // Long ticks against an unreachable delay keep the ramp pending; then a
    // delay one below the elapsed time must start the ramp.
    drain_idle();
    cfg_write(REG_START_DELAY, 32'hFFFFFFFF);
    cfg_write(REG_RAMP_LENGTH, 32'd1000);
    cfg_write(REG_TARGET_LEVEL, $urandom);
    t       = '0;
    t.sv    = 1'b1;
    t.rearm = 1'b1;
    t.dt    = '1;
    for (int i = 0; i < LongTicks; i++) begin
      t.cur = LW'($urandom);
      send_tick(t, 1'b0, '0);
      t.rearm = 1'b0;
    end
    drain_idle();
    cfg_write(REG_START_DELAY, LongTicks * 32'hFFFFF - 32'd1);
    t.dt = '0;
    send_tick(t, 1'b0, '0);
    t.dt = TickWidth'($urandom);
    send_tick(t, 1'b0, '0);
    t.sv = 1'b0;
    send_tick(t, 1'b0, '0);

    // Random ramps: mostly a rearm followed by a run of valid ticks sized to
    // walk through delay and ramp, with dropouts, stray rearms and odd steps.
    while (rand_sent < RandTicks) begin
      drain_idle();
      src_idle = $urandom_range(0, 3) != 0;
      snk_idle = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 9))
        0:       delay_v = 0;
        1:       delay_v = 32'hFFFFFFFF;
        2:       delay_v = $urandom;
        default: delay_v = $urandom_range(0, 4000);
      endcase
      case ($urandom_range(0, 9))
        0:       len_v = 0;
        1:       len_v = 32'hFFFFFFFF;
        2:       len_v = $urandom;
        default: len_v = $urandom_range(1, 20000);
      endcase
      if ($urandom_range(0, 3) != 0) cfg_write(REG_START_DELAY, delay_v);
      if ($urandom_range(0, 3) != 0) cfg_write(REG_RAMP_LENGTH, len_v);
      if ($urandom_range(0, 3) != 0) cfg_write(REG_TARGET_LEVEL, $urandom);
      n    = $urandom_range(4, 30);
      span = 34'(p_delay) + 34'(p_len);
      base = (span / n > 34'h7FFFF) ? 32'h7FFFF : 32'(span / n);
      for (int i = 0; i < n; i++) begin
        t.rearm = (i == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 39) == 0);
        t.sv    = $urandom_range(0, 29) != 0;
        t.cur   = LW'($urandom);
        case ($urandom_range(0, 9))
          0:       t.dt = '0;
          1:       t.dt = TickWidth'($urandom);
          default: t.dt = TickWidth'($urandom_range(0, 2 * base + 1));
        endcase
        send_tick(t, 1'b0, '0);
        rand_sent++;
        if (rand_sent >= CalmFrom) calm = 1'b1;
      end
    end

    drain_idle();
    repeat (60) @(posedge clk_i);
    if (ramp_out_q.size() != 0)
      report_mismatch("results never returned", 32'(ramp_out_q.size()), 32'h0);
    if (mismatches == 0) begin
      $display("tb_delayed_linear_ramp passed");
    end else begin
      $display("tb_delayed_linear_ramp failed");
    end
    $finish;
  end

endmodule
